@@ rtl/sws_pkg.sv @@
// Shared types, constants and codes of the sliding window sender.
package sws_pkg;

    localparam int MAX_PACKETS = 4096;
    localparam int MAX_WINDOW  = 64;

    localparam int CNT_W   = $clog2(MAX_PACKETS + 1);
    localparam int IDX_W   = 12;
    localparam int SEQ_W   = 32;
    localparam int WIN_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int SLOTS   = 1 << SLOT_W;
    localparam int CFG_W   = 32;
    localparam int CFGIX_W = 2;

    localparam logic [CNT_W-1:0] TOTAL_MAX = CNT_W'(MAX_PACKETS);
    localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);

    localparam logic             RESET_REPEAT_MODE    = 1'b0;
    localparam logic [WIN_W-1:0] RESET_WINDOW_LENGTH  = 7'd8;
    localparam logic [CNT_W-1:0] RESET_PACKET_TOTAL   = '0;
    localparam logic [SEQ_W-1:0] RESET_FIRST_SEQUENCE = 32'd1;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [CFGIX_W-1:0] {
        CFG_REPEAT_MODE    = 2'd0,
        CFG_WINDOW_LENGTH  = 2'd1,
        CFG_PACKET_TOTAL   = 2'd2,
        CFG_FIRST_SEQUENCE = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADV_READ,
        ST_ADV_TEST,
        ST_RS_READ,
        ST_RS_TEST,
        ST_RS_FLUSH,
        ST_CHECK,
        ST_OPEN,
        ST_SEND,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic load;
        logic restart;
        logic gbn_move;
        logic sel_mark;
        logic rs_init;
        logic adv_read;
        logic adv_step;
        logic rs_read;
        logic rs_test;
        logic rs_flush;
        logic set_finished;
        logic open;
        logic send;
        logic status;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic sel_mode;
        logic active;
        logic total_zero;
        logic gbn_ok;
        logic sel_ok;
        logic win_done;
        logic all_done;
        logic ptr_end;
        logic send_last;
        logic rd_acked;
        logic pend_valid;
    } stat_t;

endpackage

@@ rtl/sws_ctrl.sv @@
// Sequencing state machine of the sliding window sender.
module sws_ctrl
    import sws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.req == REQ_START)
                begin
                    state_next = stat.total_zero ? ST_STATUS : ST_OPEN;
                end
                else if (stat.req == REQ_ACK && stat.active)
                begin
                    if (stat.sel_mode && stat.sel_ok)
                    begin
                        state_next = ST_ADV_READ;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
                else if (stat.req == REQ_TIMEOUT && stat.active)
                begin
                    state_next = ST_RS_READ;
                end
                else
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_ADV_READ:
            begin
                state_next = stat.win_done ? ST_CHECK : ST_ADV_TEST;
            end
            ST_ADV_TEST:
            begin
                state_next = stat.rd_acked ? ST_ADV_READ : ST_CHECK;
            end
            ST_RS_READ:
            begin
                state_next = stat.ptr_end ? ST_RS_FLUSH : ST_RS_TEST;
            end
            ST_RS_TEST:
            begin
                state_next = ST_RS_READ;
            end
            ST_RS_FLUSH:
            begin
                state_next = stat.pend_valid ? ST_IDLE : ST_STATUS;
            end
            ST_CHECK:
            begin
                if (stat.win_done && !stat.all_done)
                begin
                    state_next = ST_OPEN;
                end
                else
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_OPEN:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (stat.send_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STATUS:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DISPATCH:
            begin
                cmd.restart  = (stat.req == REQ_START);
                cmd.gbn_move = (stat.req == REQ_ACK) && stat.active && !stat.sel_mode
                               && stat.gbn_ok;
                cmd.sel_mark = (stat.req == REQ_ACK) && stat.active && stat.sel_mode
                               && stat.sel_ok;
                cmd.rs_init  = 1'b1;
            end
            ST_ADV_READ:
            begin
                cmd.adv_read = !stat.win_done;
            end
            ST_ADV_TEST:
            begin
                cmd.adv_step = stat.rd_acked;
            end
            ST_RS_READ:
            begin
                cmd.rs_read = !stat.ptr_end;
            end
            ST_RS_TEST:
            begin
                cmd.rs_test = 1'b1;
            end
            ST_RS_FLUSH:
            begin
                cmd.rs_flush = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.set_finished = stat.win_done && stat.all_done;
            end
            ST_OPEN:
            begin
                cmd.open = 1'b1;
            end
            ST_SEND:
            begin
                cmd.send = 1'b1;
            end
            ST_STATUS:
            begin
                cmd.status = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/sws_datapath.sv @@
// Window registers, acknowledgement slot memory and result registers.
module sws_datapath
    import sws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFGIX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [1:0]         req_type,
    input  logic [SEQ_W-1:0]   ack_sequence,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic               strobe,
    output logic               send_valid,
    output logic [IDX_W-1:0]   packet_index,
    output logic               is_resend,
    output logic               transfer_done,
    output logic               last_result
);

    logic             repeat_mode_reg;
    logic [WIN_W-1:0] window_length_reg;
    logic [CNT_W-1:0] packet_total_reg;
    logic [SEQ_W-1:0] first_sequence_reg;

    req_t             req_reg;
    logic [SEQ_W-1:0] ack_off_reg;
    logic [CNT_W-1:0] ws_reg;
    logic [CNT_W-1:0] we_reg;
    logic             finished_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic             pend_valid_reg;
    logic [CNT_W-1:0] pend_idx_reg;

    logic             slot_mem [SLOTS];
    logic             rd_q_reg;

    logic             strobe_reg;
    logic             send_valid_reg;
    logic [IDX_W-1:0] packet_index_reg;
    logic             is_resend_reg;
    logic             transfer_done_reg;
    logic             last_result_reg;

    logic [CNT_W-1:0] total_eff;
    logic [WIN_W-1:0] win_eff;
    logic [CNT_W-1:0] end_sum;
    logic [CNT_W-1:0] end_next;
    logic [CNT_W-1:0] ptr_inc;
    logic             off_small;
    logic [CNT_W-1:0] off_low;

    logic             wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic             wr_data;
    logic             rd_en;
    logic [SLOT_W-1:0] rd_addr;

    logic             emit;
    logic             emit_send;
    logic [CNT_W-1:0] emit_idx;
    logic             emit_resend;
    logic             emit_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_mode_reg    <= RESET_REPEAT_MODE;
            window_length_reg  <= RESET_WINDOW_LENGTH;
            packet_total_reg   <= RESET_PACKET_TOTAL;
            first_sequence_reg <= RESET_FIRST_SEQUENCE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_REPEAT_MODE:    repeat_mode_reg    <= cfg_data[0];
                CFG_WINDOW_LENGTH:  window_length_reg  <= cfg_data[WIN_W-1:0];
                CFG_PACKET_TOTAL:   packet_total_reg   <= cfg_data[CNT_W-1:0];
                CFG_FIRST_SEQUENCE: first_sequence_reg <= cfg_data[SEQ_W-1:0];
                default:            repeat_mode_reg    <= repeat_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        total_eff = (packet_total_reg > TOTAL_MAX) ? TOTAL_MAX : packet_total_reg;
        if (window_length_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (window_length_reg > WIN_MAX)
        begin
            win_eff = WIN_MAX;
        end
        else
        begin
            win_eff = window_length_reg;
        end
        end_sum   = ws_reg + CNT_W'(win_eff);
        end_next  = (end_sum > total_eff) ? total_eff : end_sum;
        ptr_inc   = ptr_reg + CNT_W'(1);
        off_small = (ack_off_reg[SEQ_W-1:CNT_W] == '0);
        off_low   = ack_off_reg[CNT_W-1:0];
    end

    always_comb
    begin
        stat.req        = req_reg;
        stat.sel_mode   = repeat_mode_reg;
        stat.active     = !finished_reg && (we_reg > ws_reg);
        stat.total_zero = (total_eff == '0);
        stat.gbn_ok     = off_small && (off_low >= ws_reg) && (off_low <= we_reg);
        stat.sel_ok     = off_small && (off_low >= ws_reg) && (off_low < we_reg);
        stat.win_done   = (ws_reg >= we_reg);
        stat.all_done   = (ws_reg >= total_eff);
        stat.ptr_end    = (ptr_reg >= we_reg);
        stat.send_last  = (ptr_inc == we_reg);
        stat.rd_acked   = rd_q_reg;
        stat.pend_valid = pend_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg        <= REQ_NONE;
            ws_reg         <= '0;
            we_reg         <= '0;
            finished_reg   <= 1'b0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                req_reg <= req_t'(req_type);
            end
            if (cmd.restart)
            begin
                ws_reg       <= '0;
                we_reg       <= '0;
                finished_reg <= (total_eff == '0);
            end
            if (cmd.gbn_move)
            begin
                ws_reg <= off_low;
            end
            if (cmd.adv_step)
            begin
                ws_reg <= ws_reg + CNT_W'(1);
            end
            if (cmd.set_finished)
            begin
                finished_reg <= 1'b1;
            end
            if (cmd.rs_init)
            begin
                ptr_reg        <= ws_reg;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.open)
            begin
                we_reg  <= end_next;
                ptr_reg <= ws_reg;
            end
            if (cmd.send || cmd.rs_test)
            begin
                ptr_reg <= ptr_inc;
            end
            if (cmd.rs_test && !rd_q_reg)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ack_off_reg <= ack_sequence - first_sequence_reg;
        end
        if (cmd.rs_test && !rd_q_reg)
        begin
            pend_idx_reg <= ptr_reg;
        end
    end

    always_comb
    begin
        wr_en   = cmd.sel_mark || cmd.send;
        wr_addr = cmd.sel_mark ? off_low[SLOT_W-1:0] : ptr_reg[SLOT_W-1:0];
        wr_data = cmd.sel_mark;
        rd_en   = cmd.adv_read || cmd.rs_read;
        rd_addr = cmd.adv_read ? ws_reg[SLOT_W-1:0] : ptr_reg[SLOT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= slot_mem[rd_addr];
        end
    end

    always_comb
    begin
        emit        = 1'b0;
        emit_send   = 1'b0;
        emit_idx    = '0;
        emit_resend = 1'b0;
        emit_last   = 1'b0;
        if (cmd.send)
        begin
            emit      = 1'b1;
            emit_send = 1'b1;
            emit_idx  = ptr_reg;
            emit_last = (ptr_inc == we_reg);
        end
        else if ((cmd.rs_test && !rd_q_reg && pend_valid_reg) ||
                 (cmd.rs_flush && pend_valid_reg))
        begin
            emit        = 1'b1;
            emit_send   = 1'b1;
            emit_idx    = pend_idx_reg;
            emit_resend = 1'b1;
            emit_last   = cmd.rs_flush;
        end
        else if (cmd.status)
        begin
            emit      = 1'b1;
            emit_last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            send_valid_reg    <= emit_send;
            packet_index_reg  <= emit_idx[IDX_W-1:0];
            is_resend_reg     <= emit_resend;
            transfer_done_reg <= finished_reg;
            last_result_reg   <= emit_last;
        end
    end

    assign strobe        = strobe_reg;
    assign send_valid    = send_valid_reg;
    assign packet_index  = packet_index_reg;
    assign is_resend     = is_resend_reg;
    assign transfer_done = transfer_done_reg;
    assign last_result   = last_result_reg;

endmodule

@@ rtl/sliding_window_sender_core.sv @@
// Sliding window sender core: top level joining controller and datapath.
//
// A transaction is taken when start is high and busy is low. Results leave one
// per clock at most, each on the result ports for one cycle while strobe is
// high, and the receiver must take every one. A start, or an acknowledgement
// that releases a window, opens the window and then sends each of its packets.
// A timeout scans the window through the acknowledgement slot memory, reading
// and then testing the slot of each packet. A selective acknowledgement
// advances the window start over acknowledged packets with the same read and
// test steps. A transaction that sends nothing gives one status result after
// dispatch and any scan above. The slot memory needs no clearing: every slot in
// a window is written as its packet is sent.
module sliding_window_sender_core
    import sws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFGIX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [SEQ_W-1:0]   ack_sequence,
    output logic               strobe,
    output logic               send_valid,
    output logic [IDX_W-1:0]   packet_index,
    output logic               is_resend,
    output logic               transfer_done,
    output logic               last_result
);

    cmd_t  cmd;
    stat_t stat;

    sws_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sws_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .ack_sequence  (ack_sequence),
        .cmd           (cmd),
        .stat          (stat),
        .strobe        (strobe),
        .send_valid    (send_valid),
        .packet_index  (packet_index),
        .is_resend     (is_resend),
        .transfer_done (transfer_done),
        .last_result   (last_result)
    );

endmodule

@@ rtl/sws_checker.sv @@
// Port level checks of the sliding window sender core and their binding.
module sws_checker
    import sws_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               strobe,
    input logic               send_valid,
    input logic [IDX_W-1:0]   packet_index,
    input logic               is_resend,
    input logic               transfer_done,
    input logic               last_result
);

    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !send_valid |-> last_result && !is_resend && packet_index == '0)
        else $error("status result with send fields set");

    a_send_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && send_valid |-> !transfer_done)
        else $error("transmission reported after completion");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !strobe)
        else $error("accepted transaction did not raise busy");

    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !busy |-> last_result)
        else $error("non-final result while idle");

endmodule

bind sliding_window_sender_core sws_checker u_sws_checker (.*);
